// ----- rtl/core/sqh_pkg.sv -----
// Shared constants for the square-to-quad homography block.
// No dependencies; imported by every module under rtl/core.
`default_nettype none

package sqh_pkg;

	// default geometry of the fixed-point words
	localparam int DEF_WORD_BITS = 32;
	localparam int DEF_FRAC_BITS = 16;

	// digit width of the pipelined multipliers, one digit per stage
	localparam int MUL_DIG = 16;

endpackage

`default_nettype wire

// ----- rtl/core/sqh_mul.sv -----
// Pipelined signed multiplier: one MUL_DIG-bit digit of b per stage.
// Depends on sqh_pkg (MUL_DIG).
`default_nettype none

module sqh_mul #(
	parameter int A_BITS = 34,
	parameter int B_BITS = 33
) (
	input  wire logic                             clk,
	input  wire logic signed [A_BITS-1:0]         a,
	input  wire logic signed [B_BITS-1:0]         b,
	output logic signed      [A_BITS+B_BITS-1:0]  p
);
	import sqh_pkg::*;

	localparam int ND = (B_BITS + MUL_DIG - 1) / MUL_DIG;
	localparam int PW = A_BITS + B_BITS;
	localparam int LW = B_BITS - (ND - 1) * MUL_DIG;

	logic signed [A_BITS-1:0] a_r   [ND-1];
	logic signed [B_BITS-1:0] b_r   [ND-1];
	logic signed [PW-1:0]     acc_r [ND];

	for (genvar k = 0; k < ND; k++) begin : g_stage
		logic signed [A_BITS-1:0]         a_src;
		logic signed [B_BITS-1:0]         b_src;
		logic signed [PW-1:0]             acc_src;
		logic signed [MUL_DIG:0]          dig;
		logic signed [A_BITS+MUL_DIG:0]   pp;

		if (k == 0) begin : g_first
			assign a_src   = a;
			assign b_src   = b;
			assign acc_src = '0;
		end else begin : g_next
			assign a_src   = a_r[k-1];
			assign b_src   = b_r[k-1];
			assign acc_src = acc_r[k-1];
		end

		// top digit carries the sign, the others are unsigned
		if (k == ND - 1) begin : g_top
			assign dig = (MUL_DIG+1)'($signed(b_src[B_BITS-1 -: LW]));
		end else begin : g_low
			assign dig = {1'b0, b_src[k*MUL_DIG +: MUL_DIG]};
		end

		assign pp = a_src * dig;

		always_ff @(posedge clk) begin
			acc_r[k] <= acc_src + (PW'(pp) <<< (k * MUL_DIG));
		end

		if (k < ND - 1) begin : g_carry
			always_ff @(posedge clk) begin
				a_r[k] <= a_src;
				b_r[k] <= b_src;
			end
		end
	end

	assign p = acc_r[ND-1];

endmodule

`default_nettype wire

// ----- rtl/core/sqh_div.sv -----
// Pipelined rounding divider: round(num/den), ties away from zero,
// saturated to a signed WORD_BITS result. One quotient bit per stage.
// Depends on sqh_pkg.
`default_nettype none

module sqh_div #(
	parameter int WORD_BITS = sqh_pkg::DEF_WORD_BITS,
	parameter int NUM_BITS  = 102,
	parameter int DEN_BITS  = 68
) (
	input  wire logic                        clk,
	input  wire logic signed [NUM_BITS-1:0]  num,
	input  wire logic signed [DEN_BITS-1:0]  den,
	output logic signed      [WORD_BITS-1:0] quo,
	output logic                             ovf
);
	import sqh_pkg::*;

	localparam int W   = WORD_BITS;
	localparam int STG = W + 1;
	localparam int RA  = NUM_BITS + 1;
	localparam int RB  = DEN_BITS + 2 + W;
	localparam int RW  = (RA > RB) ? RA : RB;

	logic [NUM_BITS-1:0] mag_n;
	logic [DEN_BITS-1:0] mag_d;

	logic [RW-1:0]       rem_r [STG+1];
	logic [W:0]          q_r   [STG+1];
	logic [DEN_BITS:0]   d_r   [STG+1];
	logic                neg_r [STG+1];

	logic [W:0]          lim;
	logic                sat;
	logic [W:0]          mag;

	always_comb begin
		mag_n = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
		mag_d = den[DEN_BITS-1] ? DEN_BITS'(-den) : DEN_BITS'(den);
	end

	// prep: 2|n| + |d| over 2|d|
	always_ff @(posedge clk) begin
		rem_r[0] <= (RW'(mag_n) << 1) + RW'(mag_d);
		d_r[0]   <= {mag_d, 1'b0};
		q_r[0]   <= '0;
		neg_r[0] <= num[NUM_BITS-1] ^ den[DEN_BITS-1];
	end

	// restoring steps, quotient bit W first
	for (genvar j = 0; j < STG; j++) begin : g_step
		logic [RW-1:0] dsh;
		logic [RW:0]   diff;

		assign dsh  = RW'(d_r[j]) << (W - j);
		assign diff = {1'b0, rem_r[j]} - {1'b0, dsh};

		always_ff @(posedge clk) begin
			d_r[j+1]   <= d_r[j];
			neg_r[j+1] <= neg_r[j];
			if (!diff[RW]) begin
				rem_r[j+1]       <= diff[RW-1:0];
				q_r[j+1]         <= q_r[j] | ((W+1)'(1) << (W - j));
			end else begin
				rem_r[j+1]       <= rem_r[j];
				q_r[j+1]         <= q_r[j];
			end
		end
	end

	always_comb begin
		lim = ((W+1)'(1) << (W - 1)) - (neg_r[STG] ? (W+1)'(0) : (W+1)'(1));
		sat = q_r[STG] > lim;
		mag = sat ? lim : q_r[STG];
	end

	always_ff @(posedge clk) begin
		quo <= neg_r[STG] ? -$signed(mag[W-1:0]) : $signed(mag[W-1:0]);
		ovf <= sat;
	end

endmodule

`default_nettype wire

// ----- rtl/core/square_to_quad_homography.sv -----
// Square-to-quad homography solver, top level.
// Depends on sqh_pkg, sqh_mul, sqh_div.
//
// Usage
//   Input: raise start with the eight corner words (signed, FRAC_BITS
//   fraction bits). A beat is taken at every rising edge with start high and
//   busy low; busy is held low, so a new quad may be given every cycle.
//   Output: done pulses for one cycle with coef_a..coef_h, degenerate and
//   overflow. The receiver cannot hold results off and must take each beat.
//   Throughput: one quad per cycle. The depth is set by the two digit-serial
//   multiplier banks (16 bits of operand per stage) and by the six
//   restoring dividers, which resolve one quotient bit per stage.
//   Datapath: corner differences -> det products -> del/gn/hn ->
//   numerator products -> numerator sums -> round-and-saturate division.
//   A zero determinant yields all-zero coefficients with degenerate set and
//   overflow clear; saturated coefficients set overflow.
//   Reset clears only the valid chain; in-flight beats are dropped and done
//   stays low until new beats come through.
`default_nettype none

module square_to_quad_homography #(
	parameter int WORD_BITS = sqh_pkg::DEF_WORD_BITS,
	parameter int FRAC_BITS = sqh_pkg::DEF_FRAC_BITS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic signed [WORD_BITS-1:0] corner0_x,
	input  wire logic signed [WORD_BITS-1:0] corner0_y,
	input  wire logic signed [WORD_BITS-1:0] corner1_x,
	input  wire logic signed [WORD_BITS-1:0] corner1_y,
	input  wire logic signed [WORD_BITS-1:0] corner2_x,
	input  wire logic signed [WORD_BITS-1:0] corner2_y,
	input  wire logic signed [WORD_BITS-1:0] corner3_x,
	input  wire logic signed [WORD_BITS-1:0] corner3_y,
	output logic                             done,
	output logic signed      [WORD_BITS-1:0] coef_a,
	output logic signed      [WORD_BITS-1:0] coef_b,
	output logic signed      [WORD_BITS-1:0] coef_c,
	output logic signed      [WORD_BITS-1:0] coef_d,
	output logic signed      [WORD_BITS-1:0] coef_e,
	output logic signed      [WORD_BITS-1:0] coef_f,
	output logic signed      [WORD_BITS-1:0] coef_g,
	output logic signed      [WORD_BITS-1:0] coef_h,
	output logic                             degenerate,
	output logic                             overflow
);
	import sqh_pkg::*;

	localparam int W    = WORD_BITS;
	localparam int M    = (W + 1 + MUL_DIG - 1) / MUL_DIG;   // multiplier depth
	localparam int BW   = W + 1;                              // B operand width
	localparam int AW1  = W + 2;
	localparam int PW1  = AW1 + BW;
	localparam int DW   = 2 * W + 4;                          // del, gn, hn
	localparam int PW2  = DW + BW;
	localparam int NWA  = PW2 + 1;
	localparam int NWB  = DW + FRAC_BITS;
	localparam int NW   = (NWA > NWB) ? NWA : NWB;            // numerators
	localparam int DLAT = W + 3;                              // divider depth
	localparam int SL   = 1 + M + DLAT;                       // side-band delay
	localparam int LAT  = 4 + 2 * M + DLAT;
	localparam int XW   = 6 * W;

	// ---------------- stage 1: corner differences ----------------
	logic accept;
	logic signed [W:0]   dx1_c, dx2_c, dy1_c, dy2_c;
	logic signed [W+1:0] sx_c, sy_c;

	logic signed [W:0]   dx1_s1, dx2_s1, dy1_s1, dy2_s1;
	logic signed [W+1:0] sx_s1, sy_s1;
	logic        [XW-1:0] xs_s1;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_comb begin
		dx1_c = BW'(corner1_x) - BW'(corner2_x);
		dx2_c = BW'(corner3_x) - BW'(corner2_x);
		dy1_c = BW'(corner1_y) - BW'(corner2_y);
		dy2_c = BW'(corner3_y) - BW'(corner2_y);
		sx_c  = AW1'(corner0_x) - AW1'(corner1_x) + AW1'(corner2_x) - AW1'(corner3_x);
		sy_c  = AW1'(corner0_y) - AW1'(corner1_y) + AW1'(corner2_y) - AW1'(corner3_y);
	end

	always_ff @(posedge clk) begin
		dx1_s1 <= dx1_c;
		dx2_s1 <= dx2_c;
		dy1_s1 <= dy1_c;
		dy2_s1 <= dy2_c;
		sx_s1  <= sx_c;
		sy_s1  <= sy_c;
		xs_s1  <= {corner0_x, corner0_y, corner1_x, corner1_y, corner3_x, corner3_y};
	end

	// ---------------- determinant products ----------------
	logic signed [AW1-1:0] m1_a [6];
	logic signed [BW-1:0]  m1_b [6];
	logic signed [PW1-1:0] m1_p [6];

	always_comb begin
		m1_a[0] = AW1'(dx1_s1); m1_b[0] = dy2_s1;   // del
		m1_a[1] = AW1'(dx2_s1); m1_b[1] = dy1_s1;
		m1_a[2] = sx_s1;        m1_b[2] = dy2_s1;   // gn
		m1_a[3] = sy_s1;        m1_b[3] = dx2_s1;
		m1_a[4] = sy_s1;        m1_b[4] = dx1_s1;   // hn
		m1_a[5] = sx_s1;        m1_b[5] = dy1_s1;
	end

	for (genvar i = 0; i < 6; i++) begin : g_mul1
		sqh_mul #(.A_BITS(AW1), .B_BITS(BW)) u_mul (
			.clk (clk),
			.a   (m1_a[i]),
			.b   (m1_b[i]),
			.p   (m1_p[i])
		);
	end

	// corners ride alongside the multipliers
	logic [XW-1:0] xdly_q [M];

	always_ff @(posedge clk) begin
		xdly_q[0] <= xs_s1;
		for (int k = 1; k < M; k++) begin
			xdly_q[k] <= xdly_q[k-1];
		end
	end

	logic signed [W-1:0] x0_d, y0_d, x1_d, y1_d, x3_d, y3_d;

	always_comb begin
		x0_d = $signed(xdly_q[M-1][6*W-1 -: W]);
		y0_d = $signed(xdly_q[M-1][5*W-1 -: W]);
		x1_d = $signed(xdly_q[M-1][4*W-1 -: W]);
		y1_d = $signed(xdly_q[M-1][3*W-1 -: W]);
		x3_d = $signed(xdly_q[M-1][2*W-1 -: W]);
		y3_d = $signed(xdly_q[M-1][W-1:0]);
	end

	// ---------------- stage 2: del, gn, hn ----------------
	logic signed [DW-1:0] del_s2, gn_s2, hn_s2;
	logic signed [BW-1:0] ax_s2, bx_s2, ay_s2, by_s2;
	logic signed [BW-1:0] x1_s2, x3_s2, y1_s2, y3_s2;
	logic signed [W-1:0]  x0_s2, y0_s2;

	always_ff @(posedge clk) begin
		del_s2 <= DW'(m1_p[0]) - DW'(m1_p[1]);
		gn_s2  <= DW'(m1_p[2]) - DW'(m1_p[3]);
		hn_s2  <= DW'(m1_p[4]) - DW'(m1_p[5]);
		ax_s2  <= BW'(x1_d) - BW'(x0_d);
		bx_s2  <= BW'(x3_d) - BW'(x0_d);
		ay_s2  <= BW'(y1_d) - BW'(y0_d);
		by_s2  <= BW'(y3_d) - BW'(y0_d);
		x1_s2  <= BW'(x1_d);
		x3_s2  <= BW'(x3_d);
		y1_s2  <= BW'(y1_d);
		y3_s2  <= BW'(y3_d);
		x0_s2  <= x0_d;
		y0_s2  <= y0_d;
	end

	// ---------------- numerator products ----------------
	logic signed [DW-1:0]  m2_a [8];
	logic signed [BW-1:0]  m2_b [8];
	logic signed [PW2-1:0] m2_p [8];

	always_comb begin
		m2_a[0] = del_s2; m2_b[0] = ax_s2;   // a
		m2_a[1] = gn_s2;  m2_b[1] = x1_s2;
		m2_a[2] = del_s2; m2_b[2] = bx_s2;   // b
		m2_a[3] = hn_s2;  m2_b[3] = x3_s2;
		m2_a[4] = del_s2; m2_b[4] = ay_s2;   // d
		m2_a[5] = gn_s2;  m2_b[5] = y1_s2;
		m2_a[6] = del_s2; m2_b[6] = by_s2;   // e
		m2_a[7] = hn_s2;  m2_b[7] = y3_s2;
	end

	for (genvar i = 0; i < 8; i++) begin : g_mul2
		sqh_mul #(.A_BITS(DW), .B_BITS(BW)) u_mul (
			.clk (clk),
			.a   (m2_a[i]),
			.b   (m2_b[i]),
			.p   (m2_p[i])
		);
	end

	// gn, hn, del held for the numerator sums
	logic [3*DW-1:0] gdly_q [M];

	always_ff @(posedge clk) begin
		gdly_q[0] <= {gn_s2, hn_s2, del_s2};
		for (int k = 1; k < M; k++) begin
			gdly_q[k] <= gdly_q[k-1];
		end
	end

	// degenerate flag and pass-through coefficients wait for the dividers
	logic [2*W:0] sdly_q [SL];

	always_ff @(posedge clk) begin
		sdly_q[0] <= {del_s2 == '0, x0_s2, y0_s2};
		for (int k = 1; k < SL; k++) begin
			sdly_q[k] <= sdly_q[k-1];
		end
	end

	// ---------------- stage 3: numerator sums ----------------
	logic signed [NW-1:0] num_s3 [6];
	logic signed [DW-1:0] den_s3;

	always_ff @(posedge clk) begin
		num_s3[0] <= NW'(m2_p[0]) + NW'(m2_p[1]);
		num_s3[1] <= NW'(m2_p[2]) + NW'(m2_p[3]);
		num_s3[2] <= NW'(m2_p[4]) + NW'(m2_p[5]);
		num_s3[3] <= NW'(m2_p[6]) + NW'(m2_p[7]);
		num_s3[4] <= NW'($signed(gdly_q[M-1][3*DW-1 -: DW])) <<< FRAC_BITS;
		num_s3[5] <= NW'($signed(gdly_q[M-1][2*DW-1 -: DW])) <<< FRAC_BITS;
		den_s3    <= $signed(gdly_q[M-1][DW-1:0]);
	end

	// ---------------- division, round and saturate ----------------
	logic signed [W-1:0] quo [6];
	logic                qov [6];

	for (genvar i = 0; i < 6; i++) begin : g_div
		sqh_div #(.WORD_BITS(W), .NUM_BITS(NW), .DEN_BITS(DW)) u_div (
			.clk (clk),
			.num (num_s3[i]),
			.den (den_s3),
			.quo (quo[i]),
			.ovf (qov[i])
		);
	end

	// ---------------- output register ----------------
	logic deg_d;
	logic signed [W-1:0] x0_o, y0_o;

	always_comb begin
		deg_d = sdly_q[SL-1][2*W];
		x0_o  = $signed(sdly_q[SL-1][2*W-1 -: W]);
		y0_o  = $signed(sdly_q[SL-1][W-1:0]);
	end

	always_ff @(posedge clk) begin
		coef_a     <= deg_d ? '0 : quo[0];
		coef_b     <= deg_d ? '0 : quo[1];
		coef_c     <= deg_d ? '0 : x0_o;
		coef_d     <= deg_d ? '0 : quo[2];
		coef_e     <= deg_d ? '0 : quo[3];
		coef_f     <= deg_d ? '0 : y0_o;
		coef_g     <= deg_d ? '0 : quo[4];
		coef_h     <= deg_d ? '0 : quo[5];
		degenerate <= deg_d;
		overflow   <= !deg_d && (qov[0] || qov[1] || qov[2] || qov[3] || qov[4] || qov[5]);
	end

	// valid chain, one bit per stage
	logic [LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], accept};
		end
	end

	assign done = vld_q[LAT-1];

	// ---------------- checks ----------------
	a_deg_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(degenerate && overflow))
		else $error("degenerate and overflow both set");

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate |-> coef_a == '0 && coef_g == '0 && coef_c == '0)
		else $error("degenerate result not zeroed");

	a_passthru: assert property (@(posedge clk) disable iff (!arst_n)
		done && !degenerate |->
			coef_c == $past(corner0_x, LAT) && coef_f == $past(corner0_y, LAT))
		else $error("coef_c/coef_f misaligned with input beat");

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result beat without matching input beat");

endmodule

`default_nettype wire

// ----- tb/square_to_quad_homography_test.sv -----
// Testbench for square_to_quad_homography: random and directed quads against an exact predictor.
// Depends on sqh_pkg and square_to_quad_homography; self-checking, no files or arguments.
`timescale 1ns / 100ps
`default_nettype none

module square_to_quad_homography_test;
	import sqh_pkg::*;

	localparam int WB = DEF_WORD_BITS;
	localparam int FB = DEF_FRAC_BITS;
	localparam int LAT = WB + 7 + 2 * ((WB + 16) / 16);
	localparam int N_RANDOM = 530;
	localparam int PAUSE_AT = 150;     // sender drains the pipe once here
	localparam int CALM_LO = 250;      // beats in [CALM_LO, CALM_HI) never idle
	localparam int CALM_HI = 400;

	typedef logic signed [WB-1:0] word_t;
	// 160 bits hold every intermediate exactly (numerators stay below 2^105)
	typedef logic signed [159:0] wide_t;

	typedef struct {
		word_t x[4];
		word_t y[4];
	} quad_t;

	typedef struct {
		word_t coef[8];
		logic  degenerate;
		logic  overflow;
	} coefs_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done;
	word_t cx[4], cy[4];
	word_t co[8];
	logic degenerate, overflow;

	quad_t  quads_to_send[$];
	coefs_t coefs_due[$];
	quad_t  cur_quad;
	int     beats_taken = 0;
	bit     drained = 1'b0;
	int     mismatches = 0;
	bit     stim_done = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	square_to_quad_homography uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.corner0_x(cx[0]), .corner0_y(cy[0]), .corner1_x(cx[1]), .corner1_y(cy[1]),
		.corner2_x(cx[2]), .corner2_y(cy[2]), .corner3_x(cx[3]), .corner3_y(cy[3]),
		.done(done),
		.coef_a(co[0]), .coef_b(co[1]), .coef_c(co[2]), .coef_d(co[3]),
		.coef_e(co[4]), .coef_f(co[5]), .coef_g(co[6]), .coef_h(co[7]),
		.degenerate(degenerate), .overflow(overflow)
	);

	// n/d rounded to nearest, ties away from zero, clamped to the word range
	function automatic word_t round_div(input wide_t n, input wide_t d, inout logic ovf);
		wide_t an, ad, q;
		logic neg;
		an = n < 0 ? -n : n;
		ad = d < 0 ? -d : d;
		neg = (n < 0) != (d < 0);
		q = (2 * an + ad) / (2 * ad);
		if (neg && q > (wide_t'(1) <<< (WB - 1))) begin
			q = wide_t'(1) <<< (WB - 1);
			ovf = 1'b1;
		end else if (!neg && q > (wide_t'(1) <<< (WB - 1)) - 1) begin
			q = (wide_t'(1) <<< (WB - 1)) - 1;
			ovf = 1'b1;
		end
		return neg ? word_t'(-q) : word_t'(q);
	endfunction

	function automatic coefs_t solve_homography(input quad_t qd);
		wide_t x0, x1, x2, x3, y0, y1, y2, y3;
		wide_t dx1, dx2, dy1, dy2, sx, sy, del, gn, hn;
		coefs_t r;
		logic ovf;
		x0 = qd.x[0]; x1 = qd.x[1]; x2 = qd.x[2]; x3 = qd.x[3];
		y0 = qd.y[0]; y1 = qd.y[1]; y2 = qd.y[2]; y3 = qd.y[3];
		dx1 = x1 - x2; dx2 = x3 - x2; dy1 = y1 - y2; dy2 = y3 - y2;
		sx = x0 - x1 + x2 - x3; sy = y0 - y1 + y2 - y3;
		del = dx1 * dy2 - dx2 * dy1;
		gn = sx * dy2 - dx2 * sy;
		hn = dx1 * sy - sx * dy1;
		ovf = 1'b0;
		for (int i = 0; i < 8; i++) r.coef[i] = '0;
		r.degenerate = (del == 0);
		if (del != 0) begin
			r.coef[0] = round_div(del * (x1 - x0) + gn * x1, del, ovf);
			r.coef[1] = round_div(del * (x3 - x0) + hn * x3, del, ovf);
			r.coef[2] = qd.x[0];
			r.coef[3] = round_div(del * (y1 - y0) + gn * y1, del, ovf);
			r.coef[4] = round_div(del * (y3 - y0) + hn * y3, del, ovf);
			r.coef[5] = qd.y[0];
			r.coef[6] = round_div(gn <<< FB, del, ovf);
			r.coef[7] = round_div(hn <<< FB, del, ovf);
		end
		r.overflow = ovf;
		return r;
	endfunction

	// driver: a beat moves at every edge with start high and busy low
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				cx[i] <= '0;
				cy[i] <= '0;
			end
		end else begin
			if (start && !busy) begin
				coefs_due.push_back(solve_homography(cur_quad));
				beats_taken++;
			end
			if (start && busy) begin
				// hold the beat
			end else if (beats_taken == PAUSE_AT && !drained) begin
				// wait for the pipe to empty completely before going on
				start <= 1'b0;
				if (coefs_due.size() == 0) drained = 1'b1;
			end else if (quads_to_send.size() == 0 ||
				(!(beats_taken >= CALM_LO && beats_taken < CALM_HI) &&
				$urandom_range(99) < 16)) begin
				start <= 1'b0;
			end else begin
				cur_quad = quads_to_send.pop_front();
				start <= 1'b1;
				for (int i = 0; i < 4; i++) begin
					cx[i] <= cur_quad.x[i];
					cy[i] <= cur_quad.y[i];
				end
			end
		end
	end

	// monitor: every done cycle is one result beat
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (coefs_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat at %0t", $time);
			end else begin
				coefs_t e;
				logic bad;
				e = coefs_due.pop_front();
				bad = (degenerate !== e.degenerate) || (overflow !== e.overflow);
				for (int i = 0; i < 8; i++) if (co[i] !== e.coef[i]) bad = 1'b1;
				if (bad) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch at %0t:", $time);
						for (int i = 0; i < 8; i++)
							$display("  coef %0d exp %h got %h", i, e.coef[i], co[i]);
						$display("  degenerate exp %b got %b, overflow exp %b got %b",
							e.degenerate, degenerate, e.overflow, overflow);
					end
				end
			end
		end
	end

	function automatic word_t rnd_word(input int shift);
		return $signed($urandom) >>> shift;
	endfunction

	function automatic quad_t make_quad(input int x0, y0, x1, y1, x2, y2, x3, y3);
		quad_t q;
		q.x[0] = x0; q.y[0] = y0; q.x[1] = x1; q.y[1] = y1;
		q.x[2] = x2; q.y[2] = y2; q.x[3] = x3; q.y[3] = y3;
		return q;
	endfunction

	// plausible quad: a unit square scaled, moved and jittered
	function automatic quad_t random_quad();
		quad_t q;
		word_t cxo, cyo, sz;
		int sh;
		sh = $urandom_range(30, 4);
		cxo = rnd_word($urandom_range(31, 2));
		cyo = rnd_word($urandom_range(31, 2));
		sz = $urandom >> sh;
		q.x[0] = cxo;      q.y[0] = cyo;
		q.x[1] = cxo + sz; q.y[1] = cyo;
		q.x[2] = cxo + sz; q.y[2] = cyo + sz;
		q.x[3] = cxo;      q.y[3] = cyo + sz;
		for (int i = 0; i < 4; i++) begin
			q.x[i] += rnd_word(sh + $urandom_range(3));
			q.y[i] += rnd_word(sh + $urandom_range(3));
		end
		return q;
	endfunction

	initial begin
		int one;
		int mx;
		int mn;
		quad_t q;
		one = 1 << FB;
		mx = 32'h7fffffff;
		mn = 32'h80000000;
		// directed: identity square, parallelogram, perspective, degenerate, extremes
		quads_to_send.push_back(make_quad(0, 0, one, 0, one, one, 0, one));
		quads_to_send.push_back(make_quad(0, 0, 2*one, one, 3*one, 3*one, one, 2*one));
		quads_to_send.push_back(make_quad(0, 0, 4*one, 0, 3*one, 2*one, one, 2*one));
		quads_to_send.push_back(make_quad(one/3, -one, 5*one, one/7, 9*one, 8*one, -one, 3*one));
		quads_to_send.push_back(make_quad(7, 7, 7, 7, 7, 7, 7, 7));
		quads_to_send.push_back(make_quad(0, 0, one, one, 2*one, 2*one, 3*one, 3*one));
		quads_to_send.push_back(make_quad(0, 0, one, 0, one, 0, 0, one));
		quads_to_send.push_back(make_quad(mx, mx, mx, mx, mx, mx, mx, mx));
		quads_to_send.push_back(make_quad(mn, mn, mn, mn, mn, mn, mn, mn));
		quads_to_send.push_back(make_quad(mn, mn, mx, mn, mx, mx, mn, mx));
		quads_to_send.push_back(make_quad(mx, mx, mn, mx, mn, mn, mx, mn));
		quads_to_send.push_back(make_quad(0, 0, 1, 0, 1, 1, 0, 1));
		quads_to_send.push_back(make_quad(mx, 0, 0, mn, 1, 1, mn, mx));
		quads_to_send.push_back(make_quad(0, 0, mx, 0, 3, 5, 0, mx));
		quads_to_send.push_back(make_quad(0, 0, 1, 0, mx, mx, 0, 1));
		quads_to_send.push_back(make_quad(-one, -one, one, -one, one, one, -one, one));
		quads_to_send.push_back(make_quad(0, 0, one, 0, one/2, 1, 0, one));
		quads_to_send.push_back(make_quad(-1, -1, -1, -1, -1, -1, -1, -1));
		for (int i = 0; i < N_RANDOM; i++) begin
			case ($urandom_range(9))
				0, 1: begin
					for (int k = 0; k < 4; k++) begin
						q.x[k] = $urandom;
						q.y[k] = $urandom;
					end
				end
				2: begin
					// two corners coincide: zero determinant
					q = random_quad();
					q.x[1] = q.x[2];
					q.y[1] = q.y[2];
				end
				default: q = random_quad();
			endcase
			quads_to_send.push_back(q);
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait (quads_to_send.size() == 0);
		@(posedge clk);
		while (start || coefs_due.size() != 0) @(posedge clk);
		repeat (LAT + 10) @(posedge clk);
		if (mismatches == 0 && coefs_due.size() == 0)
			$display("square_to_quad_homography test passed");
		else
			$display("square_to_quad_homography test failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("square_to_quad_homography test failed");
		$finish;
	end

endmodule

`default_nettype wire
